### hdl/psde_pkg.sv
package psde_pkg;

  // Default sizing of the dictionary
  localparam int MAX_STATES_DEF = 256;
  localparam int LAYERS_DEF     = 70;

  // Field widths on the ports
  localparam int LO_W    = 64;
  localparam int HI_W    = 6;
  localparam int IN_BITS = LO_W + HI_W;
  localparam int IDX_OW  = 8;
  localparam int CNT_OW  = 9;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((IDX_OW + CNT_OW + 7) / 8) * 8;

  // Control flags that travel with each word along the cell chain
  typedef struct packed {
    logic valid;
    logic fs;
    logic resolved;
    logic is_new;
  } psde_ctl_t;

endpackage

### hdl/pixel_state_dictionary_encoder_unit.sv
// Channel  Dir  tdata                                     tuser
// s_axis   in   [63:0] layer_bits_lo, [69:64] layer_bits_hi  [0] frame_start
// m_axis   out  [7:0] state_index, [16:8] distinct_count     [0] is_new, [1] overflow
//
// One word is taken per cycle unless the output stalls; each word walks the chain
// of MAX_STATES cells, one cell per cycle, then the output stage registers its result.
// Each cell holds one dictionary entry; a frame start empties entries as it passes.
// Reset empties the dictionary at once (one valid flag per cell), no clearing pass.
// When the output word is held by m_axis_tready low, the whole chain stalls.
module pixel_state_dictionary_encoder_unit #(
  parameter int MAX_STATES = psde_pkg::MAX_STATES_DEF,
  parameter int LAYERS     = psde_pkg::LAYERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [63:0] layer_bits_lo, [69:64] layer_bits_hi, rest zero
  input  logic [psde_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] frame_start
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] state_index, [16:8] distinct_count, rest zero
  output logic [psde_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] is_new, [1] overflow
  output logic [1:0]                       m_axis_tuser
);

  localparam int IDX_W = $clog2(MAX_STATES);
  localparam int CNT_W = $clog2(MAX_STATES + 1);

  psde_pkg::psde_ctl_t               chain_ctl [MAX_STATES+1];
  logic [LAYERS-1:0]                 chain_vec [MAX_STATES+1];
  logic [IDX_W-1:0]                  chain_idx [MAX_STATES+1];
  logic [psde_pkg::IN_BITS-1:0]      in_full;
  logic                              en;
  logic [IDX_W-1:0]                  out_idx;
  logic                              out_new;
  logic                              out_ovf;
  logic [CNT_W-1:0]                  out_cnt;
  logic [IDX_W+psde_pkg::IDX_OW-1:0] idx_ext;
  logic [CNT_W+psde_pkg::CNT_OW-1:0] cnt_ext;

  // Drop layers beyond LAYERS before they reach the chain
  assign in_full = s_axis_tdata[psde_pkg::IN_BITS-1:0];

  assign chain_ctl[0].valid    = s_axis_tvalid;
  assign chain_ctl[0].fs       = s_axis_tuser[0];
  assign chain_ctl[0].resolved = 1'b0;
  assign chain_ctl[0].is_new   = 1'b0;
  assign chain_vec[0]          = in_full[LAYERS-1:0];
  assign chain_idx[0]          = '0;

  assign s_axis_tready = en;

  // Row of dictionary cells
  for (genvar k = 0; k < MAX_STATES; k++) begin : g_cell
    psde_cell #(
      .LAYERS     (LAYERS),
      .MAX_STATES (MAX_STATES),
      .CELL_IDX   (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_ctl  (chain_ctl[k]),
      .in_vec  (chain_vec[k]),
      .in_idx  (chain_idx[k]),
      .out_ctl (chain_ctl[k+1]),
      .out_vec (chain_vec[k+1]),
      .out_idx (chain_idx[k+1])
    );
  end

  psde_out #(
    .MAX_STATES (MAX_STATES)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (chain_ctl[MAX_STATES]),
    .in_idx  (chain_idx[MAX_STATES]),
    .m_ready (m_axis_tready),
    .en      (en),
    .m_valid (m_axis_tvalid),
    .idx_r   (out_idx),
    .new_r   (out_new),
    .ovf_r   (out_ovf),
    .cnt     (out_cnt)
  );

  // Fit index and count to the port widths
  assign idx_ext = {{psde_pkg::IDX_OW{1'b0}}, out_idx};
  assign cnt_ext = {{psde_pkg::CNT_OW{1'b0}}, out_cnt};

  assign m_axis_tdata = {{(psde_pkg::M_TDATA_W - psde_pkg::IDX_OW - psde_pkg::CNT_OW){1'b0}},
                         cnt_ext[psde_pkg::CNT_OW-1:0],
                         idx_ext[psde_pkg::IDX_OW-1:0]};
  assign m_axis_tuser = {out_ovf, out_new};

endmodule

### hdl/psde_cell.sv
module psde_cell #(
  parameter int LAYERS     = psde_pkg::LAYERS_DEF,
  parameter int MAX_STATES = psde_pkg::MAX_STATES_DEF,
  parameter int CELL_IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  psde_pkg::psde_ctl_t           in_ctl,
  input  logic [LAYERS-1:0]             in_vec,
  input  logic [$clog2(MAX_STATES)-1:0] in_idx,
  output psde_pkg::psde_ctl_t           out_ctl,
  output logic [LAYERS-1:0]             out_vec,
  output logic [$clog2(MAX_STATES)-1:0] out_idx
);

  localparam int IDX_W = $clog2(MAX_STATES);

  logic                ent_valid;
  logic [LAYERS-1:0]   ent_vec;
  logic                eff_valid;
  logic                hit;
  logic                claim;
  logic                take;
  psde_pkg::psde_ctl_t ctl_next;
  logic [IDX_W-1:0]    idx_next;

  // A frame start sees this entry as empty; an unresolved word claims the first empty entry
  assign eff_valid = ent_valid && !in_ctl.fs;
  assign hit       = eff_valid && (ent_vec == in_vec);
  assign claim     = in_ctl.valid && !in_ctl.resolved && !eff_valid;
  assign take      = in_ctl.valid && !in_ctl.resolved && (hit || claim);

  // Tag the word with this entry's index when it resolves here
  always_comb begin
    ctl_next = in_ctl;
    idx_next = in_idx;
    if (take) begin
      ctl_next.resolved = 1'b1;
      ctl_next.is_new   = claim;
      idx_next          = IDX_W'(CELL_IDX);
    end
  end

  // Hold entry state; a frame start empties it as it passes
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      out_ctl   <= '0;
    end else if (en) begin
      out_ctl <= ctl_next;
      if (claim) begin
        ent_valid <= 1'b1;
      end else if (in_ctl.valid && in_ctl.fs) begin
        ent_valid <= 1'b0;
      end
    end
  end

  // Advance payload and store a claimed vector
  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= in_vec;
      out_idx <= idx_next;
      if (claim) begin
        ent_vec <= in_vec;
      end
    end
  end

endmodule

### hdl/psde_out.sv
module psde_out #(
  parameter int MAX_STATES = psde_pkg::MAX_STATES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  psde_pkg::psde_ctl_t             in_ctl,
  input  logic [$clog2(MAX_STATES)-1:0]   in_idx,
  input  logic                            m_ready,
  output logic                            en,
  output logic                            m_valid,
  output logic [$clog2(MAX_STATES)-1:0]   idx_r,
  output logic                            new_r,
  output logic                            ovf_r,
  output logic [$clog2(MAX_STATES+1)-1:0] cnt
);

  localparam int IDX_W = $clog2(MAX_STATES);
  localparam int CNT_W = $clog2(MAX_STATES + 1);

  logic [CNT_W-1:0] cnt_next;

  // Advance the chain whenever the output slot is free or being drained
  assign en = !m_valid || m_ready;

  // Restart the count on a frame start, bump it on an insert
  assign cnt_next = (in_ctl.fs ? '0 : cnt) + CNT_W'(in_ctl.is_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      cnt     <= '0;
    end else if (en) begin
      m_valid <= in_ctl.valid;
      if (in_ctl.valid) begin
        cnt <= cnt_next;
      end
    end
  end

  // Capture the result word; an unresolved word is an overflow with index zero
  always_ff @(posedge clk) begin
    if (en && in_ctl.valid) begin
      new_r <= in_ctl.is_new;
      ovf_r <= !in_ctl.resolved;
      idx_r <= in_ctl.resolved ? in_idx : '0;
    end
  end

`ifndef ASSERT_OFF
  a_ovf_full : assert property (@(posedge clk) disable iff (rst)
    m_valid && ovf_r |-> (cnt == CNT_W'(MAX_STATES)) && !new_r)
    else $error("overflow reported while dictionary not full");

  a_new_last : assert property (@(posedge clk) disable iff (rst)
    m_valid && new_r |-> (CNT_W'(idx_r) + CNT_W'(1)) == cnt)
    else $error("new entry index is not the last stored entry");

  a_hit_below : assert property (@(posedge clk) disable iff (rst)
    m_valid && !new_r && !ovf_r |-> CNT_W'(idx_r) < cnt)
    else $error("match index beyond stored entries");

  a_cnt_max : assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_STATES))
    else $error("entry count beyond capacity");
`endif

endmodule

### dv/pixel_state_dictionary_encoder_unit_tb.sv
`timescale 1ns / 1ps

module pixel_state_dictionary_encoder_unit_tb;

  localparam int VEC_W      = psde_pkg::IN_BITS;
  localparam int DICT_DEPTH = psde_pkg::MAX_STATES_DEF;
  localparam int LAYER_CNT  = psde_pkg::LAYERS_DEF;
  localparam logic [VEC_W-1:0] LAYER_MASK =
    (LAYER_CNT >= VEC_W) ? '1 : ((VEC_W'(1) << LAYER_CNT) - 1);
  localparam int PHASE_PIXELS = 375;
  localparam int MAX_REPORTS  = 10;

  // One encoded result: index, flags and dictionary occupancy
  typedef struct packed {
    logic [psde_pkg::IDX_OW-1:0] idx;
    logic                        is_new;
    logic                        ovf;
    logic [psde_pkg::CNT_OW-1:0] cnt;
  } enc_result_t;

  // Directed row; typed marks rows whose result is written out by hand
  typedef struct packed {
    logic [63:0] lo;
    logic [5:0]  hi;
    logic        fs;
    logic        typed;
    logic [7:0]  idx;
    logic        is_new;
    logic        ovf;
    logic [8:0]  cnt;
  } pixel_row_t;

  localparam int DIR_ROWS = 20;
  localparam pixel_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty dictionary after reset, then extremes of both halves
    '{64'h0, 6'h00, 1'b0, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1},
    '{64'h0, 6'h00, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 9'd1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'h3F, 1'b0, 1'b1, 8'd1, 1'b1, 1'b0, 9'd2},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'h00, 1'b0, 1'b1, 8'd2, 1'b1, 1'b0, 9'd3},
    '{64'h0, 6'h3F, 1'b0, 1'b1, 8'd3, 1'b1, 1'b0, 9'd4},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'h3F, 1'b0, 1'b1, 8'd1, 1'b0, 1'b0, 9'd4},
    // single-bit neighbors of zero at the field edges
    '{64'h8000_0000_0000_0000, 6'h00, 1'b0, 1'b1, 8'd4, 1'b1, 1'b0, 9'd5},
    '{64'h0, 6'h20, 1'b0, 1'b1, 8'd5, 1'b1, 1'b0, 9'd6},
    '{64'h0, 6'h01, 1'b0, 1'b1, 8'd6, 1'b1, 1'b0, 9'd7},
    '{64'h1, 6'h00, 1'b0, 1'b1, 8'd7, 1'b1, 1'b0, 9'd8},
    '{64'h0, 6'h00, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 9'd8},
    '{64'h5555_5555_5555_5555, 6'h15, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 6'h2A, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    '{64'h5555_5555_5555_5555, 6'h15, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0},
    // frame start empties the dictionary
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'h3F, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1},
    '{64'h0, 6'h00, 1'b0, 1'b1, 8'd1, 1'b1, 1'b0, 9'd2},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'h3F, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 9'd2},
    '{64'h0, 6'h00, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1},
    // back-to-back frame starts
    '{64'h0, 6'h00, 1'b1, 1'b1, 8'd0, 1'b1, 1'b0, 9'd1},
    '{64'hDEAD_BEEF_0123_4567, 6'h2D, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 9'd0}
  };

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [psde_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic [0:0]                     s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [psde_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]                     m_axis_tuser;

  // Hand-written expectation that travels with the word on the input
  logic        pend_typed;
  enc_result_t pend_result;

  // Predictor state
  logic [VEC_W-1:0] dict_entries [DICT_DEPTH];
  int               dict_fill;
  enc_result_t      expected_results [$];

  int mismatch_count;
  int pixels_sent;
  int sender_idle_pct;
  int ready_stall_pct;

  pixel_state_dictionary_encoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Look the vector up, append it on a miss, flag a full dictionary
  function automatic enc_result_t encode_pixel(input logic [VEC_W-1:0] vec, input logic fs);
    logic [VEC_W-1:0] v;
    enc_result_t      r;
    bit               hit;
    int               i;
    v   = vec & LAYER_MASK;
    r   = '0;
    hit = 1'b0;
    if (fs) begin
      dict_fill = 0;
    end
    for (i = 0; i < dict_fill; i++) begin
      if (!hit && dict_entries[i] == v) begin
        hit   = 1'b1;
        r.idx = psde_pkg::IDX_OW'(i);
      end
    end
    if (!hit) begin
      if (dict_fill < DICT_DEPTH) begin
        r.idx                   = psde_pkg::IDX_OW'(dict_fill);
        dict_entries[dict_fill] = v;
        dict_fill++;
        r.is_new = 1'b1;
      end else begin
        r.ovf = 1'b1;
      end
    end
    r.cnt = psde_pkg::CNT_OW'(dict_fill);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  // Check results, then predict for the word accepted at this edge
  always @(posedge clk) begin
    enc_result_t got;
    enc_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.idx    = m_axis_tdata[psde_pkg::IDX_OW-1:0];
        got.cnt    = m_axis_tdata[psde_pkg::IDX_OW +: psde_pkg::CNT_OW];
        got.is_new = m_axis_tuser[0];
        got.ovf    = m_axis_tuser[1];
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf(
            "unexpected word: state_index %0d is_new %0b overflow %0b distinct_count %0d",
            got.idx, got.is_new, got.ovf, got.cnt));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              {"mismatch: state_index exp %0d got %0d, is_new exp %0b got %0b, ",
               "overflow exp %0b got %0b, distinct_count exp %0d got %0d"},
              want.idx, got.idx, want.is_new, got.is_new, want.ovf, got.ovf,
              want.cnt, got.cnt));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = encode_pixel(s_axis_tdata[VEC_W-1:0], s_axis_tuser[0]);
        expected_results.push_back(pend_typed ? pend_result : want);
      end
    end
  end

  // Receiver back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Offer one word, after random idle cycles, and hold it until taken
  task automatic send_pixel(input logic [VEC_W-1:0] vec, input logic fs,
                            input logic typed, input enc_result_t typed_res);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(psde_pkg::S_TDATA_W - VEC_W){1'b0}}, vec};
    s_axis_tuser  <= fs;
    pend_typed    <= typed;
    pend_result   <= typed_res;
    do @(posedge clk); while (!s_axis_tready);
    pixels_sent++;
  endtask

  function automatic logic [VEC_W-1:0] random_vector();
    logic [VEC_W-1:0] v;
    v[31:0]  = $urandom;
    v[63:32] = $urandom;
    v[69:64] = 6'($urandom_range(63));
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v = VEC_W'(1) << $urandom_range(VEC_W - 1);
      3: v = ~(VEC_W'(1) << $urandom_range(VEC_W - 1));
      default: ;
    endcase
    return v;
  endfunction

  // Frame with mostly fresh vectors: fills the dictionary and runs past it
  task automatic run_fill_frame();
    logic [VEC_W-1:0] seen [$];
    logic [VEC_W-1:0] v;
    int               len;
    int               i;
    len = $urandom_range(300, 340);
    for (i = 0; i < len; i++) begin
      if (seen.size() == 0 || $urandom_range(99) < 92) begin
        v[31:0]  = $urandom;
        v[63:32] = $urandom;
        v[69:64] = 6'($urandom_range(63));
        seen.push_back(v);
      end else begin
        v = seen[$urandom_range(seen.size() - 1)];
      end
      send_pixel(v, (i == 0), 1'b0, '0);
    end
  endtask

  // Frame drawn from a small palette, with some noise and stray frame starts
  task automatic run_small_frame();
    logic [VEC_W-1:0] palette [12];
    int               pal_n;
    int               len;
    int               i;
    logic             start_fs;
    pal_n    = $urandom_range(1, 12);
    len      = $urandom_range(4, 48);
    start_fs = ($urandom_range(99) < 85);
    for (i = 0; i < pal_n; i++) begin
      palette[i] = random_vector();
    end
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 10) begin
        send_pixel(random_vector(), ($urandom_range(99) < 5), 1'b0, '0);
      end else begin
        send_pixel(palette[$urandom_range(pal_n - 1)], (i == 0) && start_fs, 1'b0, '0);
      end
    end
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int         idle_by_phase [4];
    int         stall_by_phase [4];
    int         ph;
    int         r;
    int         phase_base;
    pixel_row_t row;
    enc_result_t typed_res;
    idle_by_phase  = '{0, 72, 0, 37};
    stall_by_phase = '{0, 0, 72, 37};
    rst             = 1'b1;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    pend_typed      = 1'b0;
    pend_result     = '0;
    dict_fill       = 0;
    mismatch_count  = 0;
    pixels_sent     = 0;
    sender_idle_pct = 0;
    ready_stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows, no idling
    for (r = 0; r < DIR_ROWS; r++) begin
      row              = DIR_TABLE[r];
      typed_res.idx    = row.idx;
      typed_res.is_new = row.is_new;
      typed_res.ovf    = row.ovf;
      typed_res.cnt    = row.cnt;
      send_pixel({row.hi, row.lo}, row.fs, row.typed, typed_res);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Random frames under each idling mix; hold off until drained between phases
    for (ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_by_phase[ph];
      ready_stall_pct = stall_by_phase[ph];
      phase_base      = pixels_sent;
      if (ph == 0 || ph == 2) begin
        run_fill_frame();
      end
      while (pixels_sent - phase_base < PHASE_PIXELS) begin
        run_small_frame();
      end
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    ready_stall_pct = 0;
    repeat (DICT_DEPTH + 50) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("pixel_state_dictionary_encoder_unit regression: pass");
    end else begin
      $display("pixel_state_dictionary_encoder_unit regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("pixel_state_dictionary_encoder_unit regression: fail");
    $finish;
  end

endmodule
